// ===== sv/sbrp_pkg.sv =====
// Shared types, constants and byte-lookup functions for the STUN binding response parser.
package sbrp_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_TXN_HIGH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TXN_LOW  = 1'b1;

    localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;
    localparam logic [16:0] HEADER_LEN = 17'd20;

    localparam logic [7:0]  MSG_CLASS    = 8'h01;
    localparam logic [7:0]  TYPE_SUCCESS = 8'h01;
    localparam logic [7:0]  TYPE_ERROR   = 8'h11;
    localparam logic [15:0] XMA_TYPE     = 16'h0020;
    localparam logic [15:0] PORT_KEY     = 16'h2112;
    localparam logic [31:0] MAGIC_COOKIE = 32'h2112A442;

    localparam logic [1:0] FAMILY_NONE = 2'd0;
    localparam logic [1:0] FAMILY_IPV4 = 2'd1;
    localparam logic [1:0] FAMILY_IPV6 = 2'd2;

    localparam logic [15:0] IPV4_ATTR_LEN = 16'd8;
    localparam logic [15:0] IPV6_ATTR_LEN = 16'd20;
    localparam logic [15:0] XMA_MIN_LEN   = 16'd4;

    typedef struct packed {
        logic        invalid;
        logic        success;
        logic [1:0]  addr_family;
        logic [15:0] port;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } sbrp_result_t;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [1:0] sel;
        sel = 2'(2'd3 - idx);
        return MAGIC_COOKIE[{sel, 3'b000} +: 8];
    endfunction

    // byte j (0..11) of the transaction id
    function automatic logic [7:0] txn_byte(input logic [31:0] txn_high,
                                            input logic [63:0] txn_low,
                                            input logic [3:0]  j);
        logic [1:0] sel_high;
        logic [3:0] rev;
        sel_high = 2'(2'd3 - j[1:0]);
        rev      = 4'(4'd11 - j);
        if (j < 4'd4)
            return txn_high[{sel_high, 3'b000} +: 8];
        return txn_low[{rev[2:0], 3'b000} +: 8];
    endfunction

    // mask byte a (0..15): cookie then transaction id
    function automatic logic [7:0] key_byte(input logic [31:0] txn_high,
                                            input logic [63:0] txn_low,
                                            input logic [3:0]  a);
        if (a < 4'd4)
            return cookie_byte(a[1:0]);
        return txn_byte(txn_high, txn_low, 4'(a - 4'd4));
    endfunction

endpackage

// ===== sv/sbrp_intf.sv =====
// Byte, result and configuration channel interfaces of the parser.
interface sbrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sbrp_result_if;
    logic        valid;
    logic        ready;
    logic        invalid;
    logic        success;
    logic [1:0]  addr_family;
    logic [15:0] port;
    logic [63:0] address_high;
    logic [63:0] address_low;

    modport source (output valid, output invalid, output success, output addr_family,
                    output port, output address_high, output address_low, input ready);
    modport sink   (input valid, input invalid, input success, input addr_family,
                    input port, input address_high, input address_low, output ready);
endinterface

interface sbrp_cfg_if
    import sbrp_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/sbrp_parser.sv =====
// Per-datagram header check and attribute walk, one byte per accepted request.
module sbrp_parser
    import sbrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  logic [31:0]  txn_id_high,
    input  logic [63:0]  txn_id_low,
    output sbrp_result_t result
);

    logic [16:0] byte_count_reg,    byte_count_next;
    logic [15:0] body_length_reg,   body_length_next;
    logic        header_bad_reg,    header_bad_next;
    logic        success_flag_reg,  success_flag_next;
    logic        error_flag_reg,    error_flag_next;
    logic [15:0] attr_type_reg,     attr_type_next;
    logic [15:0] attr_length_reg,   attr_length_next;
    logic [16:0] attr_position_reg, attr_position_next;
    logic        found_flag_reg,    found_flag_next;
    logic [1:0]  family_code_reg,   family_code_next;
    logic [15:0] port_accum_reg,    port_accum_next;
    logic [63:0] addr_high_reg,     addr_high_next;
    logic [63:0] addr_low_reg,      addr_low_next;

    logic [16:0] msg_end;
    logic [16:0] msg_end_final;
    logic [16:0] room;
    logic [15:0] len_full;
    logic [17:0] value_end;
    logic [16:0] k;
    logic [16:0] a;
    logic        xm;
    logic        capturing;
    logic        fault;
    logic [7:0]  mask_byte;
    logic [4:0]  hdr_pos;
    logic [3:0]  txn_pos;
    logic        short_frame;

    always_comb
    begin
        byte_count_next    = byte_count_reg;
        body_length_next   = body_length_reg;
        header_bad_next    = header_bad_reg;
        success_flag_next  = success_flag_reg;
        error_flag_next    = error_flag_reg;
        attr_type_next     = attr_type_reg;
        attr_length_next   = attr_length_reg;
        attr_position_next = attr_position_reg;
        found_flag_next    = found_flag_reg;
        family_code_next   = family_code_reg;
        port_accum_next    = port_accum_reg;
        addr_high_next     = addr_high_reg;
        addr_low_next      = addr_low_reg;

        msg_end   = HEADER_LEN + 17'(body_length_reg);
        room      = msg_end - byte_count_reg;
        len_full  = {attr_length_reg[15:8], data_byte};
        value_end = 18'(byte_count_reg) + 18'd1 + 18'(len_full);
        k         = attr_position_reg - 17'd4;
        a         = k - 17'd4;
        xm        = success_flag_reg && (attr_type_reg == XMA_TYPE);
        capturing = xm && !found_flag_reg && (family_code_reg != FAMILY_NONE);
        fault     = 1'b0;
        mask_byte = key_byte(txn_id_high, txn_id_low, a[3:0]);
        hdr_pos   = byte_count_reg[4:0];
        txn_pos   = 4'(hdr_pos - 5'd8);

        if (byte_count_reg < HEADER_LEN)
        begin
            case (hdr_pos) inside
                5'd0:
                begin
                    if (data_byte != MSG_CLASS)
                        header_bad_next = 1'b1;
                end
                5'd1:
                begin
                    if (data_byte == TYPE_SUCCESS)
                        success_flag_next = 1'b1;
                    else if (data_byte == TYPE_ERROR)
                        success_flag_next = 1'b0;
                    else
                        header_bad_next = 1'b1;
                end
                5'd2:
                    body_length_next = {data_byte, 8'h00};
                5'd3:
                begin
                    body_length_next = {body_length_reg[15:8], data_byte};
                    if (data_byte[1:0] != 2'b00)
                        header_bad_next = 1'b1;
                end
                [5'd4:5'd7]:
                begin
                    if (data_byte != cookie_byte(hdr_pos[1:0]))
                        header_bad_next = 1'b1;
                end
                default:
                begin
                    if (data_byte != txn_byte(txn_id_high, txn_id_low, txn_pos))
                        header_bad_next = 1'b1;
                end
            endcase
        end
        else if (!header_bad_reg && !error_flag_reg && byte_count_reg < msg_end)
        begin
            if (attr_position_reg == 17'd0)
            begin
                if (room < 17'd4)
                    error_flag_next = 1'b1;
                else
                begin
                    attr_type_next     = {data_byte, 8'h00};
                    attr_position_next = 17'd1;
                end
            end
            else if (attr_position_reg == 17'd1)
            begin
                attr_type_next     = {attr_type_reg[15:8], data_byte};
                attr_position_next = 17'd2;
            end
            else if (attr_position_reg == 17'd2)
            begin
                attr_length_next   = {data_byte, 8'h00};
                attr_position_next = 17'd3;
            end
            else if (attr_position_reg == 17'd3)
            begin
                attr_length_next = len_full;
                if (value_end > 18'(msg_end))
                    error_flag_next = 1'b1;
                else if (xm && len_full < XMA_MIN_LEN)
                    error_flag_next = 1'b1;
                else if (!xm && !attr_type_reg[15])
                    error_flag_next = 1'b1;
                else
                    attr_position_next = (len_full == 16'd0) ? 17'd0 : 17'd4;
            end
            else
            begin
                if (xm && k == 17'd1)
                begin
                    if (data_byte == 8'(FAMILY_IPV4) && attr_length_reg != IPV4_ATTR_LEN)
                        fault = 1'b1;
                    else if (data_byte == 8'(FAMILY_IPV6) && attr_length_reg != IPV6_ATTR_LEN)
                        fault = 1'b1;
                    else if (!found_flag_reg && (data_byte == 8'(FAMILY_IPV4) ||
                                                 data_byte == 8'(FAMILY_IPV6)))
                        family_code_next = data_byte[1:0];
                end
                else if (capturing && (k == 17'd2 || k == 17'd3))
                begin
                    port_accum_next = {port_accum_reg[7:0], data_byte ^
                        ((k == 17'd2) ? PORT_KEY[15:8] : PORT_KEY[7:0])};
                end
                else if (capturing && k >= 17'd4 && a < 17'd16)
                begin
                    if (family_code_reg == FAMILY_IPV6 && a < 17'd8)
                        addr_high_next = {addr_high_reg[55:0], data_byte ^ mask_byte};
                    else
                        addr_low_next = {addr_low_reg[55:0], data_byte ^ mask_byte};
                end

                if (fault)
                    error_flag_next = 1'b1;
                else if (18'(k) + 18'd1 >= 18'(attr_length_reg))
                begin
                    if (xm && family_code_next != FAMILY_NONE)
                        found_flag_next = 1'b1;
                    attr_position_next = 17'd0;
                end
                else
                    attr_position_next = attr_position_reg + 17'd1;
            end
        end

        if (byte_count_reg != COUNT_MAX)
            byte_count_next = byte_count_reg + 17'd1;

        // result as seen after this byte
        msg_end_final = HEADER_LEN + 17'(body_length_next);
        short_frame   = (byte_count_next < HEADER_LEN) || header_bad_next ||
                        (byte_count_next < msg_end_final);
        result        = '0;
        if (short_frame)
            result.invalid = 1'b1;
        else
        begin
            result.success = success_flag_next;
            result.invalid = error_flag_next || (success_flag_next && !found_flag_next);
            if (found_flag_next)
            begin
                result.addr_family = family_code_next;
                result.port        = port_accum_next;
                if (family_code_next == FAMILY_IPV6)
                begin
                    result.address_high = addr_high_next;
                    result.address_low  = addr_low_next;
                end
                else
                    result.address_low = {32'h0, addr_low_next[31:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            body_length_reg   <= '0;
            header_bad_reg    <= 1'b0;
            success_flag_reg  <= 1'b0;
            error_flag_reg    <= 1'b0;
            attr_type_reg     <= '0;
            attr_length_reg   <= '0;
            attr_position_reg <= '0;
            found_flag_reg    <= 1'b0;
            family_code_reg   <= FAMILY_NONE;
            port_accum_reg    <= '0;
            addr_high_reg     <= '0;
            addr_low_reg      <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                byte_count_reg    <= '0;
                body_length_reg   <= '0;
                header_bad_reg    <= 1'b0;
                success_flag_reg  <= 1'b0;
                error_flag_reg    <= 1'b0;
                attr_type_reg     <= '0;
                attr_length_reg   <= '0;
                attr_position_reg <= '0;
                found_flag_reg    <= 1'b0;
                family_code_reg   <= FAMILY_NONE;
                port_accum_reg    <= '0;
                addr_high_reg     <= '0;
                addr_low_reg      <= '0;
            end
            else
            begin
                byte_count_reg    <= byte_count_next;
                body_length_reg   <= body_length_next;
                header_bad_reg    <= header_bad_next;
                success_flag_reg  <= success_flag_next;
                error_flag_reg    <= error_flag_next;
                attr_type_reg     <= attr_type_next;
                attr_length_reg   <= attr_length_next;
                attr_position_reg <= attr_position_next;
                found_flag_reg    <= found_flag_next;
                family_code_reg   <= family_code_next;
                port_accum_reg    <= port_accum_next;
                addr_high_reg     <= addr_high_next;
                addr_low_reg      <= addr_low_next;
            end
        end
    end

endmodule

// ===== sv/sbrp_result_buffer.sv =====
// Output register with a skid stage for parse results.
module sbrp_result_buffer
    import sbrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  sbrp_result_t push_data,
    output logic         push_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output sbrp_result_t out_data
);

    logic         out_valid_reg;
    logic         skid_valid_reg;
    sbrp_result_t out_data_reg;
    sbrp_result_t skid_data_reg;
    logic         pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
                skid_data_reg <= push_data;
            else
                out_data_reg <= push_data;
        end
    end

endmodule

// ===== sv/stun_binding_response_parser_core.sv =====
// Top level of the STUN binding response parser.
// Takes one datagram byte per cycle with no gaps needed; every byte is
// processed in the cycle it is accepted, and the result for a datagram is
// registered on its last byte into the output register or skid stage.
// Two finished results can wait downstream (output register plus skid
// stage); byte_stream.ready falls only while both are held. The
// transaction id registers are written through cfg, which is always ready.
module stun_binding_response_parser_core
    import sbrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sbrp_byte_if.sink   byte_stream,
    sbrp_result_if.source result,
    sbrp_cfg_if.sink    cfg
);

    logic [31:0]  txn_id_high_reg;
    logic [63:0]  txn_id_low_reg;
    logic         accept;
    logic         push;
    logic         push_ready;
    sbrp_result_t parse_result;
    sbrp_result_t out_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txn_id_high_reg <= '0;
            txn_id_low_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TXN_HIGH: txn_id_high_reg <= cfg.data[31:0];
                CFG_TXN_LOW:  txn_id_low_reg  <= cfg.data;
                default:      ;
            endcase
        end
    end

    assign byte_stream.ready = push_ready;
    assign accept            = byte_stream.valid && push_ready;
    assign push              = accept && byte_stream.last_byte;

    sbrp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (byte_stream.data_byte),
        .last_byte   (byte_stream.last_byte),
        .txn_id_high (txn_id_high_reg),
        .txn_id_low  (txn_id_low_reg),
        .result      (parse_result)
    );

    sbrp_result_buffer u_result_buffer (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (parse_result),
        .push_ready (push_ready),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_data   (out_data)
    );

    assign result.invalid      = out_data.invalid;
    assign result.success      = out_data.success;
    assign result.addr_family  = out_data.addr_family;
    assign result.port         = out_data.port;
    assign result.address_high = out_data.address_high;
    assign result.address_low  = out_data.address_low;

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> result.valid)
        else $error("no result after last byte");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_stream.ready |-> result.valid)
        else $error("input stalled with no result waiting");

    a_success_has_family: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.success && !result.invalid) |->
            (result.addr_family == FAMILY_IPV4 || result.addr_family == FAMILY_IPV6))
        else $error("valid success without address");

    a_ipv4_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.addr_family != FAMILY_IPV6) |-> result.address_high == '0)
        else $error("upper address set for non-IPv6 result");

endmodule
